// ----- design/bmc_pkg.sv -----
`default_nettype none

package bmc_pkg;

  // frame size limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DIM_RST        = 1024;

  // port widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OUT_W     = 8;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  // scan position flags for the beat being taken
  typedef struct packed {
    logic drain;     // on the drain row
    logic has_out;   // a result is due (row above exists)
    logic up_ok;     // up point inside the frame
    logic left_ok;   // left point inside the frame
    logic right_ok;  // right point inside the frame
    logic last;      // result for the final pixel of the frame
    logic par;       // parity of the current input row
  } pos_t;

endpackage

`default_nettype wire

// ----- design/bmc_line_mem.sv -----
`default_nettype none

module bmc_line_mem #(
  parameter int unsigned DEPTH = bmc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic          wpar,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wbit,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [1:0]    rword    // bit 0 even row, bit 1 odd row
);

  logic mem_e [DEPTH];
  logic mem_o [DEPTH];

  logic rd_e_r;
  logic rd_o_r;
  logic byp_r;
  logic byp_par_r;
  logic byp_bit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      if (wpar) begin
        mem_o[waddr] <= wbit;
      end else begin
        mem_e[waddr] <= wbit;
      end
    end
    if (re) begin
      rd_e_r    <= mem_e[raddr];
      rd_o_r    <= mem_o[raddr];
      byp_par_r <= wpar;
      byp_bit_r <= wbit;
    end
  end

  // same-address write forwarding (only a one-pixel-wide frame hits it)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (re) begin
      byp_r <= we && (waddr == raddr);
    end
  end

  assign rword[0] = (byp_r && !byp_par_r) ? byp_bit_r : rd_e_r;
  assign rword[1] = (byp_r &&  byp_par_r) ? byp_bit_r : rd_o_r;

endmodule

`default_nettype wire

// ----- design/bmc_pos.sv -----
`default_nettype none

module bmc_pos #(
  parameter int unsigned MAX_WIDTH  = bmc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bmc_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bmc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [bmc_pkg::DIM_W-1:0]       cfg_wdata,
  input  wire logic                            adv,
  output logic                                 mode,
  output bmc_pkg::pos_t                        pos,
  output logic      [CW-1:0]                   col,
  output logic      [CW-1:0]                   rd_addr
);

  import bmc_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned W_RST = (DIM_RST > MAX_WIDTH)  ? MAX_WIDTH  : DIM_RST;
  localparam int unsigned H_RST = (DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RST;

  logic          mode_r;
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [CW-1:0] col_r;
  logic [HW-1:0] row_r;

  logic [WW-1:0] width_cl;
  logic [HW-1:0] height_cl;
  logic [CW:0]   col_p1;
  logic          eol;
  logic          drain;

  // zero reads as one, anything above the limit reads as the limit
  always_comb begin
    if (cfg_wdata == '0) begin
      width_cl  = WW'(1);
      height_cl = HW'(1);
    end else begin
      width_cl  = (32'(cfg_wdata) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(cfg_wdata);
      height_cl = (32'(cfg_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_wdata);
    end
  end

  assign col_p1 = {1'b0, col_r} + (CW+1)'(1);
  assign eol    = (32'(col_p1) == 32'(width_r));
  assign drain  = (row_r == height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ERODE;
      width_r  <= WW'(W_RST);
      height_r <= HW'(H_RST);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE: begin
          mode_r <= cfg_wdata[0];
          col_r  <= '0;
          row_r  <= '0;
        end
        CFG_WIDTH: begin
          width_r <= width_cl;
          col_r   <= '0;
          row_r   <= '0;
        end
        CFG_HEIGHT: begin
          height_r <= height_cl;
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (adv) begin
      if (eol) begin
        col_r <= '0;
        row_r <= drain ? '0 : row_r + HW'(1);
      end else begin
        col_r <= col_p1[CW-1:0];
      end
    end
  end

  assign mode    = mode_r;
  assign col     = col_r;
  assign rd_addr = eol ? '0 : col_p1[CW-1:0];

  assign pos.drain    = drain;
  assign pos.has_out  = (row_r != '0);
  assign pos.up_ok    = (32'(row_r) > 32'd1);
  assign pos.left_ok  = (col_r != '0);
  assign pos.right_ok = !eol;
  assign pos.last     = drain && eol;
  assign pos.par      = row_r[0];

endmodule

`default_nettype wire

// ----- design/binary_morphology_cross_stream.sv -----
// a result beat passes through stage 1 and the output register after the input beat that completes its window
// throughput: one input beat per cycle unless the result side stalls, results trail the input by one image row
// results for the final row come out on the width flush beats sent after the frame
// reset (rst_n low, synchronous) empties the pipeline, restarts the frame and
// loads erosion mode with a 1024 x 1024 frame; the line memory needs no clearing
`default_nettype none

module binary_morphology_cross_stream #(
  parameter int unsigned MAX_WIDTH  = bmc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bmc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input beats
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [bmc_pkg::PIX_W-1:0]      in_tdata,   // [7:0] pixel
  input  wire logic [0:0]                     in_tuser,   // [0] flush
  // result beats
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [bmc_pkg::OUT_W-1:0]      out_tdata,  // [0] out_pixel, [7:1] zero
  output logic                                out_tlast,  // frame_last
  // register writes
  input  wire logic                           cfg_we,
  input  wire logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [bmc_pkg::DIM_W-1:0]      cfg_wdata
);

  import bmc_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // scan position and registers
  logic          mode;
  pos_t          pos;
  logic [CW-1:0] col;
  logic [CW-1:0] rd_addr;

  // input side
  logic          in_acc;
  logic          in_eff;     // beat that moves the scan (early flush does not)
  logic          pix_bit;

  // window words: bit 0 even row, bit 1 odd row
  logic [1:0]    w_right;
  logic [1:0]    w_cent_r;
  logic [1:0]    w_left_r;

  // stage 1
  logic          s1_vld_r;
  pos_t          s1_pos_r;
  logic          s1_down_r;
  logic          s1_go;

  // window evaluation
  logic          rsel;
  logic [4:0]    win;        // centre, up, down, left, right from bit 0
  logic          res;

  // output register
  logic          out_vld_r;
  logic          out_pix_r;
  logic          out_last_r;

  bmc_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .adv       (in_eff),
    .mode      (mode),
    .pos       (pos),
    .col       (col),
    .rd_addr   (rd_addr)
  );

  // the stage moves whenever the output register is free or being emptied
  assign s1_go     = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign in_eff    = in_acc && !(in_tuser[0] && !pos.drain);

  // pixel reduced to one bit on arrival; drain beats carry zero
  always_comb begin
    if (pos.drain) begin
      pix_bit = 1'b0;
    end else if (mode == MODE_DILATE) begin
      pix_bit = (in_tdata == PIX_W'(1));
    end else begin
      pix_bit = (in_tdata != '0);
    end
  end

  // two rows of bits, one column word read ahead on every scan step
  bmc_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (in_eff && !pos.drain),
    .wpar  (pos.par),
    .waddr (col),
    .wbit  (pix_bit),
    .re    (in_eff),
    .raddr (rd_addr),
    .rword (w_right)
  );

  // column words slide left as the scan moves one column
  always_ff @(posedge clk) begin
    if (in_eff) begin
      w_cent_r <= w_right;
      w_left_r <= w_cent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_eff && pos.has_out;
    end
  end

  always_ff @(posedge clk) begin
    if (in_eff) begin
      s1_pos_r  <= pos;
      s1_down_r <= pix_bit;
    end
  end

  // the row being finished sits on the parity opposite the input row,
  // the row above it shares the input row's parity
  assign rsel   = ~s1_pos_r.par;
  assign win[0] = w_cent_r[rsel];
  assign win[1] = s1_pos_r.up_ok && w_cent_r[s1_pos_r.par];
  assign win[2] = s1_down_r;
  assign win[3] = s1_pos_r.left_ok && w_left_r[rsel];
  assign win[4] = s1_pos_r.right_ok && w_right[rsel];

  // erosion needs every point set, dilation any one
  assign res = (mode == MODE_DILATE) ? (|win) : (&win);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_vld_r) begin
      out_pix_r  <= res;
      out_last_r <= s1_pos_r.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_W-1){1'b0}}, out_pix_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- design/bmc_chk.sv -----
`default_nettype none

module bmc_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [bmc_pkg::OUT_W-1:0]      out_tdata,
  input wire logic                           out_tlast
);

  // a result beat stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // a fresh result comes from an input beat taken through stage 1 into the output register
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result with no matching input beat");

  // with the output register empty the input never stalls
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // only bit 0 of the result data carries information, tlast is never unknown
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[bmc_pkg::OUT_W-1:1] == '0) && !$isunknown(out_tlast))
    else $error("result padding bits set");

endmodule

bind binary_morphology_cross_stream bmc_chk u_bmc_chk (.*);

`default_nettype wire

// ----- tb/sv/tb_binary_morphology_cross_stream.sv -----
`default_nettype none

module tb_binary_morphology_cross_stream;
  import bmc_pkg::*;

  localparam int unsigned MAX_W       = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H       = DEF_MAX_HEIGHT;
  // index past the last register, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned SETTLE      = 8;      // cycles after the last result before a write
  localparam int unsigned HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int unsigned RANDOM_BEATS = 500;
  localparam int unsigned WHOLE_FRAME = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             flush;
  } pix_beat_t;

  typedef struct packed {
    logic pix;
    logic last;
  } morph_res_t;

  // dut ports
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata = '0;    // [7:0] pixel
  logic [0:0]           in_tuser = '0;    // [0] flush
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;        // [0] out_pixel, [7:1] zero
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MODE;
  logic [DIM_W-1:0]     cfg_wdata = '0;

  binary_morphology_cross_stream dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state: registers, scan position and the two-row bit store
  logic        pred_mode;
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned scan_row;
  int unsigned scan_col;
  logic        line_bits [0:1][0:MAX_W-1];

  pix_beat_t   pixel_backlog [$];   // beats waiting for the driver
  morph_res_t  expected_morph [$];  // results predicted, not yet seen
  pix_beat_t   beat;
  morph_res_t  want;

  int unsigned beats_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  // idling controls, changed by the stimulus only on falling edges
  bit          send_gaps_on = 1'b1;
  bit          recv_gaps_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_cnt = 0;

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_scan();
    scan_row = 0;
    scan_col = 0;
  endfunction

  // one accepted input beat through the cross window
  function automatic void morph_step(logic [PIX_W-1:0] pix, logic flush);
    logic        on_drain;
    logic        bit_in;
    logic [4:0]  win;
    int unsigned rr;
    morph_res_t  res;
    on_drain = (scan_row >= frame_h);
    // a flush while frame pixels are still due is dropped
    if (flush && !on_drain) return;
    bit_in = 1'b0;
    if (!on_drain) bit_in = (pred_mode == MODE_DILATE) ? (pix == 8'd1) : (pix != 8'd0);
    if (scan_row >= 1) begin
      rr = scan_row - 1;
      // bit0 centre, bit1 up, bit2 down, bit3 left, bit4 right
      win[0] = line_bits[rr % 2][scan_col];
      win[1] = (rr >= 1) ? line_bits[(rr - 1) % 2][scan_col] : 1'b0;
      win[2] = (rr + 1 < frame_h) ? bit_in : 1'b0;
      win[3] = (scan_col >= 1) ? line_bits[rr % 2][scan_col - 1] : 1'b0;
      win[4] = (scan_col + 1 < frame_w) ? line_bits[rr % 2][scan_col + 1] : 1'b0;
      res.pix  = (pred_mode == MODE_DILATE) ? (|win) : (&win);
      res.last = (rr == frame_h - 1) && (scan_col == frame_w - 1);
      expected_morph.push_back(res);
    end
    if (!on_drain) line_bits[scan_row % 2][scan_col] = bit_in;
    scan_col++;
    if (scan_col >= frame_w) begin
      scan_col = 0;
      scan_row++;
      // past the drain row a new frame starts
      if (scan_row > frame_h) restart_scan();
    end
  endfunction

  // register write while the block is idle, predictor follows
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_MODE:   pred_mode = val[0];
      CFG_WIDTH:  frame_w = clamp_dim(val, MAX_W);
      CFG_HEIGHT: frame_h = clamp_dim(val, MAX_H);
      default:    return;
    endcase
    // any write to a real register restarts the frame
    restart_scan();
  endtask

  // backlog drained, all results in, and a further SETTLE wait for beats with no result
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_tvalid || expected_morph.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic queue_beat(logic [PIX_W-1:0] pix, logic flush);
    pixel_backlog.push_back('{pix: pix, flush: flush});
    beats_queued++;
  endtask

  // pixel values that make both outcomes common in the given mode
  function automatic logic [PIX_W-1:0] draw_pixel(logic m);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (m == MODE_ERODE) begin
      if (r < 16) return PIX_W'($urandom_range(1, 255));
      if (r < 18) return 8'd0;
      return PIX_W'($urandom);
    end
    if (r < 5) return 8'd1;
    if (r < 14) return 8'd0;
    return PIX_W'($urandom);
  endfunction

  // frame in raster order then its drain row; beats numbered from .. upto-1 are queued,
  // with a stray early flush now and then and a surplus pixel now and then on the drain row
  task automatic queue_frame(int unsigned w, int unsigned h, logic m, int unsigned from,
                             int unsigned upto);
    int unsigned n;
    n = 0;
    for (int unsigned r = 0; r <= h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if (n >= upto) return;
        if (n >= from) begin
          if (r < h) begin
            if ($urandom_range(0, 31) == 0) queue_beat(PIX_W'($urandom), 1'b1);
            queue_beat(draw_pixel(m), 1'b0);
          end else if ($urandom_range(0, 19) == 0) begin
            queue_beat(PIX_W'($urandom), 1'b0);
          end else begin
            queue_beat(PIX_W'($urandom), 1'b1);
          end
        end
        n++;
      end
    end
  endtask

  // driver: next beat from the backlog, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) morph_step(in_tdata, in_tuser[0]);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          beat = pixel_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= beat.pix;
          in_tuser  <= beat.flush;
          send_gap = pick_gap(send_gaps_on);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat, drives tready with stalls and hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_morph.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = expected_morph.pop_front();
          if (out_tdata[0] !== want.pix)
            flag_mismatch($sformatf("out_pixel %b, expected %b", out_tdata[0], want.pix));
          if (out_tdata[OUT_W-1:1] !== '0)
            flag_mismatch($sformatf("tdata pad bits %b, expected zero", out_tdata[OUT_W-1:1]));
          if (out_tlast !== want.last)
            flag_mismatch($sformatf("frame_last %b, expected %b", out_tlast, want.last));
        end
        results_seen++;
      end
      // a new hold-off request starts a long stretch with tready low
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap = pick_gap(recv_gaps_on);
      end
    end
  end

  // stimulus
  initial begin
    logic [PIX_W-1:0] erode_px [9] = '{8'd255, 8'd1, 8'd128, 8'd7, 8'd255, 8'd64,
                                       8'd2, 8'd4, 8'd8};
    logic [PIX_W-1:0] dilate_px [9] = '{8'd1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd2,
                                        8'd0, 8'd0, 8'd1};
    int unsigned random_start;
    int unsigned w;
    int unsigned h;
    int unsigned kind;
    logic        m;

    // reset state of the predictor; the store starts cleared
    pred_mode = MODE_ERODE;
    frame_w = DIM_RST;
    frame_h = DIM_RST;
    restart_scan();
    foreach (line_bits[i, j]) line_bits[i][j] = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: erosion on a 1024 wide frame, first results after one full row
    queue_frame(DIM_RST, DIM_RST, MODE_ERODE, 0, 1040);
    wait_idle();

    // directed 3x3 erosion: early flush, all-nonzero centre, surplus pixel on drain row
    write_reg(CFG_MODE, {10'd0, MODE_ERODE});
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd3);
    queue_beat(8'd0, 1'b1);
    foreach (erode_px[i]) begin
      queue_beat(erode_px[i], 1'b0);
      if (i == 5) queue_beat(8'd255, 1'b1);
    end
    queue_beat(8'd0, 1'b1);
    queue_beat(8'd255, 1'b0);
    queue_beat(8'd0, 1'b1);
    wait_idle();

    // directed 3x3 dilation: only a value of exactly one counts
    write_reg(CFG_MODE, {10'd0, MODE_DILATE});
    foreach (dilate_px[i]) queue_beat(dilate_px[i], 1'b0);
    repeat (3) queue_beat(8'd1, 1'b1);
    wait_idle();

    // zero sizes read as one: a 1x1 frame
    write_reg(CFG_WIDTH, 11'd0);
    write_reg(CFG_HEIGHT, 11'd0);
    queue_beat(8'd1, 1'b0);
    queue_beat(8'd0, 1'b1);
    queue_beat(8'd0, 1'b0);
    queue_beat(8'd0, 1'b1);
    wait_idle();

    // back pressure: receiver holds off while the sender keeps offering beats
    write_reg(CFG_WIDTH, 11'd16);
    write_reg(CFG_HEIGHT, 11'd12);
    write_reg(CFG_MODE, {10'd0, MODE_ERODE});
    send_gaps_on = 1'b0;
    hold_req++;
    queue_frame(frame_w, frame_h, pred_mode, 0, WHOLE_FRAME);
    wait_idle();
    send_gaps_on = 1'b1;

    // sender stops mid-frame until all results are in, then a write to the
    // spare index, which must not restart the frame
    write_reg(CFG_WIDTH, 11'd10);
    write_reg(CFG_HEIGHT, 11'd8);
    queue_frame(frame_w, frame_h, pred_mode, 0, 45);
    wait_idle();
    write_reg(CFG_SPARE, DIM_W'($urandom));
    queue_frame(frame_w, frame_h, pred_mode, 45, WHOLE_FRAME);
    wait_idle();

    // random phases: mostly whole frames, some cut short, some noise
    random_start = beats_queued;
    while (beats_queued - random_start < RANDOM_BEATS) begin
      send_gaps_on = ($urandom_range(0, 3) != 0);
      recv_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        m = $urandom_range(0, 1);
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
        if ($urandom_range(0, 1) == 0) begin
          write_reg(CFG_HEIGHT, DIM_W'(h));
          write_reg(CFG_MODE, {10'($urandom), m});
          write_reg(CFG_WIDTH, DIM_W'(w));
        end else begin
          write_reg(CFG_MODE, {10'($urandom), m});
          write_reg(CFG_WIDTH, DIM_W'(w));
          write_reg(CFG_HEIGHT, DIM_W'(h));
        end
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // noise: arbitrary pixels and flushes at wherever the scan stands
        repeat ($urandom_range(5, 40))
          queue_beat(PIX_W'($urandom), ($urandom_range(0, 2) == 0));
      end else if (kind == 1) begin
        // frame cut short, the next write starts over
        queue_frame(frame_w, frame_h, pred_mode, 0,
                    $urandom_range(1, frame_w * (frame_h + 1) - 1));
      end else begin
        // one to three frames back to back
        repeat ($urandom_range(1, 3))
          queue_frame(frame_w, frame_h, pred_mode, 0, WHOLE_FRAME);
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
